// ----- src/hc_pkg.sv -----
`timescale 1ns / 1ps

package hc_pkg;

  localparam int unsigned KeyW    = 5;
  localparam int unsigned LetterW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SumW    = 11;
  localparam int unsigned ProdW   = 10;

  localparam logic [CfgIdxW-1:0] CFG_KEY_A   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_B   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_C   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_D   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DECRYPT = 3'd4;

  localparam logic [KeyW-1:0]    MODULUS    = 5'd26;
  localparam logic [SumW-1:0]    MOD_SQ     = 11'd676;
  localparam logic [LetterW-1:0] ASCII_Z    = 8'h7a;
  localparam logic [LetterW-1:0] ASCII_A    = 8'h61;
  localparam logic [LetterW-1:0] ASCII_Y    = 8'h79;
  localparam logic [LetterW-1:0] ASCII_BASE = 8'h60;
  // floor(2^13 / 26), used for the reciprocal reduction
  localparam logic [19:0]        RECIP_26   = 20'd315;

  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic mul_live;  // form pair sums from the word being taken
    logic mul_held;  // form pair sums from the stored pair
    logic mod_pair;  // reduce pair sums
    logic det_prod;  // form ad - bc
    logic det_mod;   // reduce det and look up its inverse
    logic key_prod;  // form adjugate times inverse
    logic key_mod;   // reduce and store the inverse key
    logic out_sel;   // 0 first result, 1 second result
  } hc_cmd_t;

  typedef struct packed {
    logic pair_done; // this word completes a pair
    logic need_inv;  // decrypting and inverse key is stale
  } hc_stat_t;

  function automatic logic [ProdW-1:0] mul5(input logic [KeyW-1:0] x,
                                            input logic [KeyW-1:0] y);
    return {5'b0, x} * {5'b0, y};
  endfunction

  // x mod 26 for x below 2048: reciprocal estimate is low by at most one
  function automatic logic [KeyW-1:0] mod26(input logic [SumW-1:0] x);
    logic [19:0]     prod;
    logic [6:0]      q;
    logic [SumW-1:0] r;
    prod = {9'b0, x} * RECIP_26;
    q    = prod[19:13];
    r    = x - ({4'b0, q} * 11'd26);
    if (r >= 11'd26) begin
      r = r - 11'd26;
    end
    return r[KeyW-1:0];
  endfunction

  function automatic logic [KeyW-1:0] red26(input logic [KeyW-1:0] k);
    return (k >= MODULUS) ? k - MODULUS : k;
  endfunction

  function automatic logic [KeyW-1:0] neg26(input logic [KeyW-1:0] k);
    return (k == 5'd0) ? 5'd0 : MODULUS - k;
  endfunction

  // multiplicative inverse mod 26, zero when none exists
  function automatic logic [KeyW-1:0] inv26(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    case (k)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // returns {bad, index}; 'z' is 0, 'a'..'y' are 1..25
  function automatic logic [KeyW:0] to_index(input logic [LetterW-1:0] ch);
    logic [LetterW-1:0] diff;
    diff = ch - ASCII_BASE;
    if (ch == ASCII_Z) begin
      return {1'b0, 5'd0};
    end else if (ch >= ASCII_A && ch <= ASCII_Y) begin
      return {1'b0, diff[KeyW-1:0]};
    end
    return {1'b1, 5'd0};
  endfunction

  function automatic logic [LetterW-1:0] to_ascii(input logic [KeyW-1:0] r);
    return (r == 5'd0) ? ASCII_Z : ASCII_BASE + {3'b0, r};
  endfunction

endpackage

// ----- src/hc_ctrl.sv -----
`timescale 1ns / 1ps

module hc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  hc_pkg::hc_stat_t stat_i,
  output hc_pkg::hc_cmd_t  cmd_o
);
  import hc_pkg::*;

  typedef enum logic [3:0] {
    S_IN,
    S_DPROD,
    S_DMOD,
    S_KPROD,
    S_KMOD,
    S_MPROD,
    S_MMOD,
    S_OUT0,
    S_OUT1
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.pair_done) begin
            if (stat_i.need_inv) begin
              state_d = S_DPROD;
            end else begin
              cmd_o.mul_live = 1'b1;
              state_d        = S_MMOD;
            end
          end
        end
      end
      S_DPROD: begin
        cmd_o.det_prod = 1'b1;
        state_d        = S_DMOD;
      end
      S_DMOD: begin
        cmd_o.det_mod = 1'b1;
        state_d       = S_KPROD;
      end
      S_KPROD: begin
        cmd_o.key_prod = 1'b1;
        state_d        = S_KMOD;
      end
      S_KMOD: begin
        cmd_o.key_mod = 1'b1;
        state_d       = S_MPROD;
      end
      S_MPROD: begin
        cmd_o.mul_held = 1'b1;
        state_d        = S_MMOD;
      end
      S_MMOD: begin
        cmd_o.mod_pair = 1'b1;
        state_d        = S_OUT0;
      end
      S_OUT0: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_OUT1;
        end
      end
      S_OUT1: begin
        out_valid_o   = 1'b1;
        cmd_o.out_sel = 1'b1;
        if (out_ready_i) begin
          state_d = S_IN;
        end
      end
      default: begin
        state_d = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output handshakes open together");

  a_second_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !cmd_o.out_sel) |=> (out_valid_o && cmd_o.out_sel))
    else $error("second result word did not follow the first");

  a_idle_after_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && cmd_o.out_sel) |=> in_ready_o)
    else $error("not back to input after second result word");

endmodule

// ----- src/hc_dp.sv -----
`timescale 1ns / 1ps

module hc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [hc_pkg::KeyW-1:0]       cfg_data_i,
  input  logic [hc_pkg::LetterW-1:0]    letter_in_i,
  input  logic                          message_end_i,
  input  hc_pkg::hc_cmd_t               cmd_i,
  output hc_pkg::hc_stat_t              stat_o,
  output logic [hc_pkg::LetterW-1:0]    letter_out_o,
  output logic                          run_last_o,
  output logic                          key_singular_o,
  output logic                          bad_letter_o
);
  import hc_pkg::*;

  // configuration
  logic [KeyW-1:0] key_a_q, key_b_q, key_c_q, key_d_q;
  logic            decrypt_q;
  // pairing state
  logic [KeyW-1:0] held_idx_q;
  logic            half_q, held_bad_q;
  // inverse key
  logic [KeyW-1:0] ik_q [4];
  logic            inv_ready_q, inv_missing_q;
  logic [SumW-1:0] detsum_q;
  logic [KeyW-1:0] inv_q;
  logic [ProdW-1:0] kp_q [4];
  // pair datapath
  logic [KeyW-1:0] p0_q, p1_q;
  logic            pair_bad_q, end_q;
  logic [SumW-1:0] sum0_q, sum1_q;
  logic [KeyW-1:0] r0_q, r1_q;

  logic [KeyW:0]   conv;
  logic [KeyW-1:0] idx, ka, kb, kc, kd;
  logic [KeyW-1:0] lp0, lp1, sp0, sp1;
  logic [KeyW-1:0] m0, m1, m2, m3;
  logic            lbad;

  assign conv = to_index(letter_in_i);
  assign idx  = conv[KeyW-1:0];
  assign ka   = red26(key_a_q);
  assign kb   = red26(key_b_q);
  assign kc   = red26(key_c_q);
  assign kd   = red26(key_d_q);

  // pair as it forms from the word now offered; lone last letter pads with 'z'
  assign lp0  = half_q ? held_idx_q : idx;
  assign lp1  = half_q ? idx : 5'd0;
  assign lbad = half_q ? (held_bad_q | conv[KeyW]) : conv[KeyW];

  assign sp0 = cmd_i.mul_held ? p0_q : lp0;
  assign sp1 = cmd_i.mul_held ? p1_q : lp1;

  assign m0 = decrypt_q ? ik_q[0] : ka;
  assign m1 = decrypt_q ? ik_q[1] : kb;
  assign m2 = decrypt_q ? ik_q[2] : kc;
  assign m3 = decrypt_q ? ik_q[3] : kd;

  assign stat_o.pair_done = half_q | message_end_i;
  assign stat_o.need_inv  = decrypt_q & ~inv_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a_q       <= 5'd1;
      key_b_q       <= 5'd0;
      key_c_q       <= 5'd0;
      key_d_q       <= 5'd1;
      decrypt_q     <= 1'b0;
      held_idx_q    <= '0;
      half_q        <= 1'b0;
      held_bad_q    <= 1'b0;
      inv_ready_q   <= 1'b0;
      inv_missing_q <= 1'b0;
    end else begin
      if (cmd_i.key_mod) begin
        inv_ready_q   <= 1'b1;
        inv_missing_q <= (inv_q == 5'd0);
      end
      if (cmd_i.accept) begin
        if (!half_q && !message_end_i) begin
          held_idx_q <= idx;
          held_bad_q <= conv[KeyW];
          half_q     <= 1'b1;
        end else begin
          held_idx_q <= '0;
          held_bad_q <= 1'b0;
          half_q     <= 1'b0;
        end
      end
      // any write to a known register makes the inverse key stale
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_A: begin
            key_a_q     <= cfg_data_i;
            inv_ready_q <= 1'b0;
          end
          CFG_KEY_B: begin
            key_b_q     <= cfg_data_i;
            inv_ready_q <= 1'b0;
          end
          CFG_KEY_C: begin
            key_c_q     <= cfg_data_i;
            inv_ready_q <= 1'b0;
          end
          CFG_KEY_D: begin
            key_d_q     <= cfg_data_i;
            inv_ready_q <= 1'b0;
          end
          CFG_DECRYPT: begin
            decrypt_q   <= cfg_data_i[0];
            inv_ready_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && stat_o.pair_done) begin
      p0_q       <= lp0;
      p1_q       <= lp1;
      pair_bad_q <= lbad;
      end_q      <= message_end_i;
    end
    if (cmd_i.det_prod) begin
      detsum_q <= {1'b0, mul5(ka, kd)} + MOD_SQ - {1'b0, mul5(kb, kc)};
    end
    if (cmd_i.det_mod) begin
      inv_q <= inv26(mod26(detsum_q));
    end
    if (cmd_i.key_prod) begin
      kp_q[0] <= mul5(kd, inv_q);
      kp_q[1] <= mul5(neg26(kb), inv_q);
      kp_q[2] <= mul5(neg26(kc), inv_q);
      kp_q[3] <= mul5(ka, inv_q);
    end
    if (cmd_i.key_mod) begin
      for (int i = 0; i < 4; i++) begin
        ik_q[i] <= mod26({1'b0, kp_q[i]});
      end
    end
    if (cmd_i.mul_live || cmd_i.mul_held) begin
      sum0_q <= {1'b0, mul5(m0, sp0)} + {1'b0, mul5(m1, sp1)};
      sum1_q <= {1'b0, mul5(m2, sp0)} + {1'b0, mul5(m3, sp1)};
    end
    if (cmd_i.mod_pair) begin
      r0_q <= mod26(sum0_q);
      r1_q <= mod26(sum1_q);
    end
  end

  assign letter_out_o   = to_ascii(cmd_i.out_sel ? r1_q : r0_q);
  assign run_last_o     = cmd_i.out_sel & end_q;
  assign key_singular_o = decrypt_q & inv_missing_q;
  assign bad_letter_o   = pair_bad_q;

  a_inv_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.key_mod && !cfg_we_i) |=> inv_ready_q)
    else $error("inverse key not marked ready after derivation");

  a_hold_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && !half_q && !message_end_i) |=> half_q)
    else $error("first letter of pair not held");

  a_pair_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && (half_q || message_end_i)) |=> (!half_q && held_idx_q == 5'd0))
    else $error("held letter not cleared after pair");

endmodule

// ----- src/hill_cipher_2x2_mod26.sv -----
`timescale 1ns / 1ps

// Hill cipher on letter pairs with a 2x2 key mod 26. One ASCII letter enters
// per input word ('z' is 0, 'a'..'y' are 1..25); the first letter of a pair is
// held. The second letter (or a lone letter with message_end, padded with 'z')
// yields two result words, and any stall on the output side holds the pair. The
// controller steps one pair at a time: accept with products, reduction, then
// the two result words in turn. In decrypt mode the first pair after any write
// to a key or mode register also derives the inverse key, which adds the steps
// determinant product, determinant reduction and inverse lookup, adjugate
// products, reduction, pair products. In decrypt mode a key with no inverse
// mod 26 gives 'z' letters with key_singular set. Non-letters count as 'z' and
// set bad_letter on both words of their pair. Write registers only while the
// block is idle.
module hill_cipher_2x2_mod26 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [hc_pkg::KeyW-1:0]       cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hc_pkg::LetterW-1:0]    letter_in_i,
  input  logic                          message_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hc_pkg::LetterW-1:0]    letter_out_o,
  output logic                          run_last_o,
  output logic                          key_singular_o,
  output logic                          bad_letter_o
);
  import hc_pkg::*;

  hc_cmd_t  cmd;
  hc_stat_t stat;

  hc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .letter_in_i    (letter_in_i),
    .message_end_i  (message_end_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .letter_out_o   (letter_out_o),
    .run_last_o     (run_last_o),
    .key_singular_o (key_singular_o),
    .bad_letter_o   (bad_letter_o)
  );

endmodule
